@@ src/urf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_pkg
// Shared types and constants of the ultrasonic range filter.
// ----------------------------------------------------------------------------
package urf_pkg;

  localparam int unsigned EchoW    = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned RawW     = 15;
  localparam int unsigned FiltW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned DistW    = 18;
  localparam int unsigned CntW     = 32;
  localparam int unsigned SmoothW  = 24;
  localparam int unsigned NumCnt   = 8;
  localparam int unsigned ProdW    = FiltW + GainW;
  localparam int unsigned ExpXW    = RawW + 8;
  localparam int unsigned ExpPW    = ExpXW + 15;

  localparam logic [14:0]      RawScale  = 15'd17983;
  localparam logic [14:0]      ExpAlpha  = 15'd22938;
  localparam logic [15:0]      ExpBeta   = 16'd42598;
  localparam logic [DistW-1:0] DistMax   = 18'h3FFFF;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StTimeout = 3'd1;
  localparam logic [StatusW-1:0] StRange   = 3'd2;
  localparam logic [StatusW-1:0] StShort   = 3'd3;
  localparam logic [StatusW-1:0] StLong    = 3'd4;
  localparam logic [StatusW-1:0] StSensor  = 3'd5;
  localparam logic [StatusW-1:0] StInvalid = 3'd6;
  localparam logic [StatusW-1:0] StOther   = 3'd7;

  localparam logic [1:0] ModeNone   = 2'd0;
  localparam logic [1:0] ModeMedian = 2'd1;
  localparam logic [1:0] ModeMean   = 2'd2;
  localparam logic [1:0] ModeExp    = 2'd3;

  localparam logic RegMode = 1'b0;
  localparam logic RegGain = 1'b1;

  localparam logic [1:0]       ModeReset = ModeMedian;
  localparam logic [GainW-1:0] GainReset = 16'd4096;

  typedef struct packed {
    logic               filt;
    logic [RawW-1:0]    raw;
    logic [StatusW-1:0] status;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic             idx;
    logic [GainW-1:0] data;
  } cfg_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MED  = 8'b0000_1000,
    S_EXP1 = 8'b0001_0000,
    S_EXP2 = 8'b0010_0000,
    S_CAL  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

endpackage

@@ src/ultrasonic_range_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_filter
// Ultrasonic reading filter: raw distance, status counters, window or
// exponential filter and Q4.12 gain.
// ----------------------------------------------------------------------------
// Readings enter on the in channel (valid/ready) and are converted to a raw
// distance on entry, then held in a two-word queue. The back sequencer takes
// one word at a time, updates the counters, runs the selected filter, scales
// by the gain and loads the result register on the out channel.
// Path of a reading from queue to result register:
//   rejected reading: straight to the result register; no filter: gain only;
//   exponential: states EXP1 and EXP2 (the first reading only seeds it);
//   median: a scan of the filled window (one candidate per cycle);
//   mean: a sum of the filled window, then the bit-serial divider.
// The divider and the median candidate scan set the rate.
// The queue keeps accepting readings while a result waits; when the
// receiver stalls the result word holds and the back stops once the next
// result is ready, after which the queue fills and in_ready_o drops.
// Reset clears counters, filter state and control registers (mode median,
// gain 1.0), not the result register. Configuration words (index 0 mode, 1 gain) are taken every cycle.
// ----------------------------------------------------------------------------
module ultrasonic_range_filter #(
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] echo_time_us_i,
  input  logic [2:0]  read_status_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] distance_q4_o,
  output logic        distance_valid_o,
  output logic [14:0] raw_distance_q4_o,
  output logic [31:0] read_count_o,
  output logic [31:0] ok_count_o,
  output logic [31:0] timeout_count_o,
  output logic [31:0] out_of_range_count_o,
  output logic [31:0] short_echo_count_o,
  output logic [31:0] long_echo_count_o,
  output logic [31:0] sensor_error_count_o,
  output logic [31:0] invalid_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  urf_pkg::entry_t  push_entry, pop_entry;
  urf_pkg::cfg_t    cfg;
  logic             push, pop, full, empty;
  logic [31:0]      cnt [urf_pkg::NumCnt];

  assign cfg_ready_o = 1'b1;
  assign cfg.we      = cfg_valid_i;
  assign cfg.idx     = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  urf_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .echo_time_us_i (echo_time_us_i),
    .read_status_i  (read_status_i),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  urf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  urf_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .empty_i           (empty),
    .entry_i           (pop_entry),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .distance_q4_o     (distance_q4_o),
    .distance_valid_o  (distance_valid_o),
    .raw_distance_q4_o (raw_distance_q4_o),
    .cnt_o             (cnt)
  );

  assign read_count_o         = cnt[0];
  assign ok_count_o           = cnt[1];
  assign timeout_count_o      = cnt[2];
  assign out_of_range_count_o = cnt[3];
  assign short_echo_count_o   = cnt[4];
  assign long_echo_count_o    = cnt[5];
  assign sensor_error_count_o = cnt[6];
  assign invalid_count_o      = cnt[7];

endmodule

@@ src/urf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_front
// Takes readings, converts echo time to raw distance and classifies them.
// ----------------------------------------------------------------------------
module urf_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [urf_pkg::EchoW-1:0]   echo_time_us_i,
  input  logic [urf_pkg::StatusW-1:0] read_status_i,
  input  logic                        full_i,
  output logic                        push_o,
  output urf_pkg::entry_t             entry_o
);

  logic [30:0] scaled;

  assign scaled         = echo_time_us_i * urf_pkg::RawScale;
  assign entry_o.raw    = scaled[30:16];
  assign entry_o.status = read_status_i;
  assign entry_o.filt   = (read_status_i == urf_pkg::StOk) && (scaled[30:16] != '0);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

@@ src/urf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module urf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  urf_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output urf_pkg::entry_t entry_o
);

  urf_pkg::entry_t mem_q [2];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ src/urf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_back
// Counters, window filters, exponential average, gain and result register.
// ----------------------------------------------------------------------------
module urf_back #(
  parameter int unsigned WINDOW_DEPTH = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  urf_pkg::cfg_t               cfg_i,
  input  logic                        empty_i,
  input  urf_pkg::entry_t             entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [urf_pkg::DistW-1:0]   distance_q4_o,
  output logic                        distance_valid_o,
  output logic [urf_pkg::RawW-1:0]    raw_distance_q4_o,
  output logic [urf_pkg::CntW-1:0]    cnt_o [urf_pkg::NumCnt]
);

  localparam int unsigned IW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW = urf_pkg::RawW + CW;
  localparam int unsigned StW  = $clog2(SumW + 1);

  urf_pkg::state_e state_q, state_d;

  logic [1:0]                   mode_q;
  logic [urf_pkg::GainW-1:0]    gain_q;
  logic [IW-1:0]                wslot_q;
  logic [CW-1:0]                filled_q, j_q, rem_q;
  logic [StW-1:0]               step_q;
  logic [urf_pkg::SmoothW-1:0]  s_q;
  logic                         started_q, out_valid_q;
  logic [urf_pkg::CntW-1:0]     cnt_q [urf_pkg::NumCnt];
  logic [urf_pkg::CntW-1:0]     ocnt_q [urf_pkg::NumCnt];

  logic [urf_pkg::RawW-1:0]     win_q [WINDOW_DEPTH];
  logic [urf_pkg::RawW-1:0]     raw_q, cand;
  logic [urf_pkg::FiltW-1:0]    f_q;
  logic [urf_pkg::ProdW-1:0]    prod_q;
  logic [SumW-1:0]              sum_q, dq_q, sum_nx, dq_nx;
  logic [urf_pkg::ExpPW-1:0]    p_q;
  logic                         res_valid_q;
  logic [urf_pkg::DistW-1:0]    dist_q;
  logic                         dval_q;
  logic [urf_pkg::RawW-1:0]     oraw_q;

  logic [CW-1:0]                kth, less, leq, rem_nx;
  logic                         hit, ge, load_out;
  logic [CW:0]                  t;
  logic [40:0]                  exp_sum;
  logic [urf_pkg::SmoothW-1:0]  s_nx;
  logic [32:0]                  dsum;
  logic [20:0]                  dfull;
  logic [urf_pkg::DistW-1:0]    dist_nx;

  assign pop_o    = (state_q == urf_pkg::S_IDLE) && !empty_i;
  assign cand     = win_q[j_q[IW-1:0]];
  assign kth      = filled_q >> 1;
  assign load_out = (state_q == urf_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    less = '0;
    leq  = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (CW'(i) < filled_q) begin
        if (win_q[i] < cand) less = less + 1'b1;
        if (win_q[i] <= cand) leq = leq + 1'b1;
      end
    end
    hit = (less <= kth) && (kth < leq);
  end

  always_comb begin
    sum_nx  = sum_q + SumW'(cand);
    t       = {rem_q, dq_q[SumW-1]};
    ge      = t >= {1'b0, filled_q};
    rem_nx  = ge ? CW'(t - {1'b0, filled_q}) : t[CW-1:0];
    dq_nx   = {dq_q[SumW-2:0], ge};
    exp_sum = 41'(p_q) + 41'(urf_pkg::ExpBeta) * 41'(s_q) + 41'd32768;
    s_nx    = exp_sum[39:16];
    dsum    = {1'b0, prod_q} + 33'd2048;
    dfull   = dsum[32:12];
    dist_nx = (dfull > 21'(urf_pkg::DistMax)) ? urf_pkg::DistMax : dfull[17:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      urf_pkg::S_IDLE: begin
        if (!empty_i) begin
          if (!entry_i.filt) begin
            state_d = urf_pkg::S_DONE;
          end else begin
            case (mode_q)
              urf_pkg::ModeMedian: state_d = urf_pkg::S_MED;
              urf_pkg::ModeMean:   state_d = urf_pkg::S_SUM;
              urf_pkg::ModeExp:    state_d = started_q ? urf_pkg::S_EXP1 : urf_pkg::S_CAL;
              default:             state_d = urf_pkg::S_CAL;
            endcase
          end
        end
      end
      urf_pkg::S_SUM:  if (j_q == filled_q - 1'b1) state_d = urf_pkg::S_DIV;
      urf_pkg::S_DIV:  if (step_q == StW'(SumW - 1)) state_d = urf_pkg::S_CAL;
      urf_pkg::S_MED:  if (hit || j_q == filled_q - 1'b1) state_d = urf_pkg::S_CAL;
      urf_pkg::S_EXP1: state_d = urf_pkg::S_EXP2;
      urf_pkg::S_EXP2: state_d = urf_pkg::S_CAL;
      urf_pkg::S_CAL:  state_d = urf_pkg::S_DONE;
      urf_pkg::S_DONE: if (load_out) state_d = urf_pkg::S_IDLE;
      default:         state_d = urf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urf_pkg::S_IDLE;
      mode_q      <= urf_pkg::ModeReset;
      gain_q      <= urf_pkg::GainReset;
      wslot_q     <= '0;
      filled_q    <= '0;
      s_q         <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < urf_pkg::NumCnt; k++) cnt_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.we) begin
        if (cfg_i.idx == urf_pkg::RegMode) begin
          mode_q    <= cfg_i.data[1:0];
          wslot_q   <= '0;
          filled_q  <= '0;
          s_q       <= '0;
          started_q <= 1'b0;
        end else if (cfg_i.idx == urf_pkg::RegGain) begin
          gain_q <= cfg_i.data;
        end
      end
      if (pop_o) begin
        cnt_q[0] <= cnt_q[0] + 1'b1;
        for (int k = 1; k < urf_pkg::NumCnt; k++) begin
          if (entry_i.status == urf_pkg::StatusW'(k - 1)) cnt_q[k] <= cnt_q[k] + 1'b1;
        end
        if (entry_i.filt && (mode_q == urf_pkg::ModeMedian || mode_q == urf_pkg::ModeMean)) begin
          wslot_q <= (wslot_q == IW'(WINDOW_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
          if (filled_q != CW'(WINDOW_DEPTH)) filled_q <= filled_q + 1'b1;
        end
        if (entry_i.filt && mode_q == urf_pkg::ModeExp && !started_q) begin
          s_q       <= {entry_i.raw, 8'd0};
          started_q <= 1'b1;
        end
      end
      if (state_q == urf_pkg::S_EXP2) s_q <= s_nx;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      urf_pkg::S_IDLE: begin
        j_q   <= '0;
        sum_q <= '0;
        if (pop_o) begin
          raw_q       <= entry_i.raw;
          res_valid_q <= entry_i.filt;
          f_q         <= urf_pkg::FiltW'(entry_i.raw);
          if (entry_i.filt &&
              (mode_q == urf_pkg::ModeMedian || mode_q == urf_pkg::ModeMean)) begin
            win_q[wslot_q] <= entry_i.raw;
          end
        end
      end
      urf_pkg::S_SUM: begin
        j_q    <= j_q + 1'b1;
        sum_q  <= sum_nx;
        dq_q   <= sum_nx;
        rem_q  <= '0;
        step_q <= '0;
      end
      urf_pkg::S_DIV: begin
        dq_q   <= dq_nx;
        rem_q  <= rem_nx;
        step_q <= step_q + 1'b1;
        f_q    <= dq_nx[urf_pkg::FiltW-1:0];
      end
      urf_pkg::S_MED: begin
        j_q <= j_q + 1'b1;
        f_q <= urf_pkg::FiltW'(cand);
      end
      urf_pkg::S_EXP1: begin
        p_q <= urf_pkg::ExpAlpha * {raw_q, 8'd0};
      end
      urf_pkg::S_EXP2: begin
        f_q <= s_nx[urf_pkg::SmoothW-1:8];
      end
      urf_pkg::S_CAL: begin
        prod_q      <= f_q * gain_q;
        res_valid_q <= res_valid_q && (f_q != '0);
      end
      urf_pkg::S_DONE: begin
        if (load_out) begin
          dval_q <= res_valid_q;
          dist_q <= res_valid_q ? dist_nx : '0;
          oraw_q <= raw_q;
          for (int k = 0; k < urf_pkg::NumCnt; k++) ocnt_q[k] <= cnt_q[k];
        end
      end
      default: begin
        j_q <= '0;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign distance_q4_o     = dist_q;
  assign distance_valid_o  = dval_q;
  assign raw_distance_q4_o = oraw_q;
  assign cnt_o             = ocnt_q;

endmodule

@@ src/urf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_checker
// Port-level checks of the ultrasonic range filter.
// ----------------------------------------------------------------------------
module urf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [17:0] distance_q4_o,
  input logic        distance_valid_o,
  input logic [14:0] raw_distance_q4_o,
  input logic [31:0] read_count_o,
  input logic [31:0] ok_count_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_count_o)
      && $stable(distance_q4_o))
    else $error("result word changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !distance_valid_o |-> distance_q4_o == 18'd0)
    else $error("invalid result with nonzero distance");

  a_valid_needs_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && distance_valid_o |-> raw_distance_q4_o != 15'd0)
    else $error("valid distance from zero raw distance");

  a_valid_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && distance_valid_o |-> ok_count_o != 32'd0 && read_count_o != 32'd0)
    else $error("valid distance without an ok reading");

endmodule

bind ultrasonic_range_filter urf_checker u_urf_checker (.*);
